// ===== rtl/men_pkg.sv =====
// Shared types, codes and constants of the mutual exclusion node.
`timescale 1ns / 1ps
package men_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int CLOCK_BITS    = 16;
  localparam int ID_W          = 4;
  localparam int COUNT_W       = 5;
  localparam int STAMP_W       = 16;
  localparam int REPLY_CNT_W   = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 5;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MY_ID      = 1'd1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_MESSAGE = 2'd1,
    CMD_RELEASE = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ACT_SEND_REQUEST = 2'd0,
    ACT_SEND_REPLY   = 2'd1,
    ACT_ENTERED      = 2'd2,
    ACT_REPLY_ERROR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_WANTED   = 2'd1,
    PH_HELD     = 2'd2
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic sweep_run;
    logic single_run;
  } men_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic want_sweep;
    logic want_single;
    logic sweep_fin;
    logic out_free;
  } men_status_t;

endpackage

// ===== rtl/men_ctrl.sv =====
// Sequencing state machine of the mutual exclusion node.
`timescale 1ns / 1ps
module men_ctrl
  import men_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  men_status_t status,
  output men_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_SINGLE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.want_sweep) begin
          state_next = S_SWEEP;
        end else if (status.want_single) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (status.sweep_fin) begin
          state_next = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready       = (state == S_IDLE);
  assign cmd.load_in    = in_valid && (state == S_IDLE);
  assign cmd.exec       = (state == S_EXEC);
  assign cmd.sweep_run  = (state == S_SWEEP);
  assign cmd.single_run = (state == S_SINGLE);

endmodule

// ===== rtl/men_datapath.sv =====
// Protocol state, clock logic, send sweep and output register of the node.
`timescale 1ns / 1ps
module men_datapath
  import men_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  men_cmd_t              cmd,
  output men_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            command,
  input  logic [ID_W-1:0]       msg_sender,
  input  logic [STAMP_W-1:0]    msg_stamp,
  input  logic                  msg_kind,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            action,
  output logic [ID_W-1:0]       destination,
  output logic [STAMP_W-1:0]    stamp_out,
  output logic                  last
);

  // Node ids are ID_W bits wide on every port, so the group size is fixed.
  localparam int MAX_NODES = MAX_NODES_DEF;
  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int N_W   = $clog2(MAX_NODES + 1);

  // Configuration and protocol state.
  logic [COUNT_W-1:0]     node_count;
  logic [ID_W-1:0]        my_id;
  phase_t                 phase;
  logic [CLOCK_BITS-1:0]  lamport_clock;
  logic [CLOCK_BITS-1:0]  request_stamp;
  logic [REPLY_CNT_W-1:0] reply_count;
  logic [MAX_NODES-1:0]   deferred_set;

  // Latched item.
  logic [1:0]         in_cmd;
  logic [ID_W-1:0]    in_sender;
  logic [STAMP_W-1:0] in_stamp;
  logic               in_kind;

  // Send sweep and pending single result.
  logic [MAX_NODES-1:0] sweep_mask;
  logic [IDX_W-1:0]     sweep_idx;
  action_t              sweep_action;
  action_t              single_action;
  logic [ID_W-1:0]      single_dest;

  // Output register.
  action_t            out_action;
  logic [ID_W-1:0]    out_dest;
  logic [STAMP_W-1:0] out_stamp;
  logic               out_last;

  logic [N_W-1:0]         eff_n;
  logic [MAX_NODES-1:0]   member_mask;
  logic [MAX_NODES-1:0]   self_mask;
  logic [MAX_NODES-1:0]   sender_mask;
  logic [MAX_NODES-1:0]   cur_onehot;
  logic [MAX_NODES-1:0]   bcast_mask;
  logic [MAX_NODES-1:0]   release_mask;
  logic [MAX_NODES-1:0]   remain_mask;
  logic [CLOCK_BITS-1:0]  stamp_ext;
  logic [CLOCK_BITS-1:0]  clk_max;
  logic [CLOCK_BITS-1:0]  msg_clock;
  logic [CLOCK_BITS-1:0]  tick_clock;
  logic [REPLY_CNT_W-1:0] reply_inc;
  logic                   sender_ok;
  logic                   defer;
  logic                   enter;
  logic                   cur_bit;
  logic                   sweep_last;
  logic                   out_free;
  logic                   emit_sweep;
  logic                   emit_single;
  action_t                single_action_next;

  // Node count clamped to the supported range.
  always_comb begin
    if (node_count < COUNT_W'(2)) begin
      eff_n = N_W'(2);
    end else if (32'(node_count) > MAX_NODES) begin
      eff_n = N_W'(MAX_NODES);
    end else begin
      eff_n = N_W'(node_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      member_mask[i] = (i < 32'(eff_n));
      self_mask[i]   = (i == 32'(my_id));
      sender_mask[i] = (i == 32'(in_sender));
      cur_onehot[i]  = (i == 32'(sweep_idx));
    end
  end

  assign bcast_mask   = member_mask & ~self_mask;
  assign release_mask = deferred_set & member_mask;

  // Lamport clock: merge with the received stamp, then tick with saturation.
  assign stamp_ext  = CLOCK_BITS'(in_stamp);
  assign clk_max    = (stamp_ext > lamport_clock) ? stamp_ext : lamport_clock;
  assign msg_clock  = (&clk_max) ? clk_max : clk_max + CLOCK_BITS'(1);
  assign tick_clock = (&lamport_clock) ? lamport_clock : lamport_clock + CLOCK_BITS'(1);

  assign sender_ok = (32'(in_sender) < 32'(eff_n)) && (in_sender != my_id);

  // An incoming request waits while the region is held, or while our own
  // request is older (equal stamps go to the lower id).
  assign defer = (phase == PH_HELD) ||
                 ((phase == PH_WANTED) &&
                  ((request_stamp < stamp_ext) ||
                   ((request_stamp == stamp_ext) && (my_id < in_sender))));

  assign reply_inc = reply_count + REPLY_CNT_W'(1);
  assign enter     = (32'(reply_inc) == (32'(eff_n) - 32'd1));

  always_comb begin
    if (in_kind == KIND_REQUEST) begin
      single_action_next = ACT_SEND_REPLY;
    end else if (phase != PH_WANTED) begin
      single_action_next = ACT_REPLY_ERROR;
    end else begin
      single_action_next = ACT_ENTERED;
    end
  end

  assign cur_bit     = |(sweep_mask & cur_onehot);
  assign remain_mask = sweep_mask & ~cur_onehot;
  assign sweep_last  = ~|remain_mask;
  assign out_free    = !out_valid || out_ready;
  assign emit_sweep  = cmd.sweep_run && cur_bit && out_free;
  assign emit_single = cmd.single_run && out_free;

  assign status.want_sweep  = (in_cmd == CMD_REQUEST) ||
                              ((in_cmd == CMD_RELEASE) && (|release_mask));
  assign status.want_single = (in_cmd == CMD_MESSAGE) && sender_ok &&
                              (((in_kind == KIND_REQUEST) && !defer) ||
                               ((in_kind == KIND_REPLY) &&
                                ((phase != PH_WANTED) || enter)));
  assign status.sweep_fin   = cur_bit && sweep_last && out_free;
  assign status.out_free    = out_free;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= NODE_COUNT_RST;
      my_id         <= '0;
      phase         <= PH_RELEASED;
      lamport_clock <= '0;
      request_stamp <= '0;
      reply_count   <= '0;
      deferred_set  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data[COUNT_W-1:0];
          REG_MY_ID:      my_id      <= cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (in_cmd)
          CMD_REQUEST: begin
            phase         <= PH_WANTED;
            lamport_clock <= tick_clock;
            request_stamp <= tick_clock;
            reply_count   <= '0;
          end
          CMD_MESSAGE: begin
            lamport_clock <= msg_clock;
            if (sender_ok) begin
              if (in_kind == KIND_REQUEST) begin
                if (defer) begin
                  deferred_set <= deferred_set | sender_mask;
                end
              end else if (phase == PH_WANTED) begin
                reply_count <= reply_inc;
                if (enter) begin
                  phase <= PH_HELD;
                end
              end
            end
          end
          CMD_RELEASE: begin
            deferred_set <= '0;
            phase        <= PH_RELEASED;
          end
          default: ;
        endcase
      end
      if (emit_sweep || emit_single) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd    <= command;
      in_sender <= msg_sender;
      in_stamp  <= msg_stamp;
      in_kind   <= msg_kind;
    end
    if (cmd.exec) begin
      sweep_idx     <= '0;
      sweep_mask    <= (in_cmd == CMD_REQUEST) ? bcast_mask : release_mask;
      sweep_action  <= (in_cmd == CMD_REQUEST) ? ACT_SEND_REQUEST : ACT_SEND_REPLY;
      single_action <= single_action_next;
      single_dest   <= (in_kind == KIND_REQUEST) ? in_sender : '0;
    end else if (cmd.sweep_run) begin
      if (!cur_bit) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end else if (out_free) begin
        sweep_idx  <= sweep_idx + IDX_W'(1);
        sweep_mask <= remain_mask;
      end
    end
    if (emit_sweep) begin
      out_action <= sweep_action;
      out_dest   <= ID_W'(sweep_idx);
      out_stamp  <= STAMP_W'(lamport_clock);
      out_last   <= sweep_last;
    end else if (emit_single) begin
      out_action <= single_action;
      out_dest   <= single_dest;
      out_stamp  <= STAMP_W'(lamport_clock);
      out_last   <= 1'b1;
    end
  end

  assign action      = out_action;
  assign destination = out_dest;
  assign stamp_out   = out_stamp;
  assign last        = out_last;

endmodule

// ===== rtl/mutual_exclusion_node_unit.sv =====
// Top level of one node of distributed mutual exclusion with a Lamport clock.
//
//  Channel   Direction  Handshake               Contents
//  config    in         cfg_we                  cfg_index, cfg_data
//  input     in         in_valid / in_ready     command, msg_sender, msg_stamp, msg_kind
//  output    out        out_valid / out_ready   action, destination, stamp_out, last
//
// An accepted item is first applied to the protocol state in the execute state and
// is then finished if it has no result. An item with a single result then waits
// until the output is free. A local request or a release with deferred replies
// scans the node ids from zero upwards, one id per cycle unless the output stalls,
// up to the last id that gets a message.
// Reset is synchronous and active high; it clears the protocol state, sets the
// node count to two and this node's id to zero, and empties the output register.
// A stalled output holds the scan at its current id; the next item is taken as
// soon as the last result of the previous one sits in the output register.
`timescale 1ns / 1ps
module mutual_exclusion_node_unit
  import men_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [ID_W-1:0]       msg_sender,
  input  logic [STAMP_W-1:0]    msg_stamp,
  input  logic                  msg_kind,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            action,
  output logic [ID_W-1:0]       destination,
  output logic [STAMP_W-1:0]    stamp_out,
  output logic                  last
);

  // The controller only sequences the phases of an item; all protocol state,
  // the send scan and the output register live in the datapath.
  men_cmd_t    cmd;
  men_status_t status;

  men_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The deferred set and the scan mask are as wide as the largest group; the
  // scan counter is just wide enough to index them.
  men_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .msg_sender  (msg_sender),
    .msg_stamp   (msg_stamp),
    .msg_kind    (msg_kind),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .action      (action),
    .destination (destination),
    .stamp_out   (stamp_out),
    .last        (last)
  );

endmodule
